>>> rtl/swm_pkg.sv
// Shared types and constants for the screen wipe mask unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package swm_pkg;

    // Default geometry, handed to the top level parameters
    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int BLIND_COUNT_DEF   = 8;

    // Fixed wipe constants
    localparam int RADIUS_PER_STEP = 3;
    localparam int SHRINK_START    = 468;
    localparam int CLOSE_STRIP     = 40;
    localparam int BLOCK_GRID      = 8;

    // Fixed-point shift of the reciprocal used for division by a period
    localparam int RECIP_SHIFT = 16;

    // Register map
    localparam int REG_WIPE_MODE = 0;
    localparam int MODE_W        = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_CIRCLE_GROW   = 4'd0,
        MODE_CIRCLE_SHRINK = 4'd1,
        MODE_DOWN          = 4'd2,
        MODE_UP            = 4'd3,
        MODE_LEFT          = 4'd4,
        MODE_RIGHT         = 4'd5,
        MODE_COL_BLINDS    = 4'd6,
        MODE_ROW_BLINDS    = 4'd7,
        MODE_CLOSE         = 4'd8,
        MODE_MID           = 4'd9,
        MODE_BLOCKS        = 4'd10
    } t_wipe_mode;

    // Operands handed from the arithmetic stages to the compare stage
    typedef struct packed {
        logic [9:0]         x;
        logic [8:0]         y;
        logic [9:0]         s;
        logic [23:0]        old_pixel;
        logic [23:0]        new_pixel;
        logic [21:0]        d2;        // dx^2 + dy^2
        logic [23:0]        r0sq;      // (3s)^2
        logic               r1_neg;    // shrink radius below zero
        logic [17:0]        r1sq;      // shrink radius squared
        logic [15:0]        rc;        // close strip width
        logic signed [11:0] wmx;       // W-1-x
        logic signed [11:0] ws;        // W-1-s
        logic signed [11:0] hs;        // H-1-s
        logic [10:0]        absdx;
        logic [9:0]         mod_cb;    // x mod column period
        logic [9:0]         mod_rb;    // y mod row period
        logic [8:0]         blk_sum;   // block column + block row
    } t_geom;

    function automatic int period_or_one(input int p);
        return (p > 0) ? p : 1;
    endfunction

endpackage

>>> rtl/swm_apb.sv
// APB-style configuration register for the wipe mask unit (wipe mode).
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [swm_pkg::MODE_W-1:0] o_mode
);
    import swm_pkg::*;

    logic [MODE_W-1:0] r_wipe_mode;
    logic              w_hit;

    // word index is paddr[2]; byte lanes ignored
    assign w_hit  = (paddr[2] == 1'(REG_WIPE_MODE));
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe_mode <= MODE_CIRCLE_GROW;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_wipe_mode <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = w_hit ? {{(32-MODE_W){1'b0}}, r_wipe_mode} : 32'd0;
    assign o_mode = r_wipe_mode;

endmodule

>>> rtl/swm_geom.sv
// Three arithmetic stages of the wipe mask: offsets, squares, remainders.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_geom #(
    parameter int SCREEN_WIDTH  = swm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = swm_pkg::SCREEN_HEIGHT_DEF,
    parameter int BLIND_COUNT   = swm_pkg::BLIND_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [9:0]     i_pixel_x,
    input  logic [8:0]     i_pixel_y,
    input  logic [9:0]     i_step_index,
    input  logic [23:0]    i_old_pixel,
    input  logic [23:0]    i_new_pixel,
    output logic           o_valid,
    input  logic           i_ready,
    output swm_pkg::t_geom o_geom
);
    import swm_pkg::*;

    localparam int PCB = period_or_one(SCREEN_WIDTH / BLIND_COUNT);
    localparam int PRB = period_or_one(SCREEN_HEIGHT / BLIND_COUNT);
    localparam int PBX = period_or_one(SCREEN_WIDTH / BLOCK_GRID);
    localparam int PBY = period_or_one(SCREEN_HEIGHT / BLOCK_GRID);
    localparam int MCB = (1 << RECIP_SHIFT) / PCB;
    localparam int MRB = (1 << RECIP_SHIFT) / PRB;
    localparam int MBX = (1 << RECIP_SHIFT) / PBX;
    localparam int MBY = (1 << RECIP_SHIFT) / PBY;

    localparam logic signed [11:0] CX     = 12'(SCREEN_WIDTH / 2);
    localparam logic signed [11:0] CY     = 12'(SCREEN_HEIGHT / 2);
    localparam logic signed [11:0] W_LAST = 12'(SCREEN_WIDTH - 1);
    localparam logic signed [11:0] H_LAST = 12'(SCREEN_HEIGHT - 1);

    typedef struct packed {
        logic [9:0]         x;
        logic [8:0]         y;
        logic [9:0]         s;
        logic [23:0]        old_pixel;
        logic [23:0]        new_pixel;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic [11:0]        r0;
        logic signed [12:0] r1;
        logic [15:0]        rc;
        logic signed [11:0] wmx;
        logic signed [11:0] ws;
        logic signed [11:0] hs;
        logic [7:0]         qcb;
        logic [7:0]         qrb;
        logic [7:0]         qbx;
        logic [7:0]         qby;
    } t_s1;

    typedef struct packed {
        logic [9:0]         x;
        logic [8:0]         y;
        logic [9:0]         s;
        logic [23:0]        old_pixel;
        logic [23:0]        new_pixel;
        logic [20:0]        dx2;
        logic [20:0]        dy2;
        logic [23:0]        r0sq;
        logic               r1_neg;
        logic [17:0]        r1sq;
        logic [15:0]        rc;
        logic signed [11:0] wmx;
        logic signed [11:0] ws;
        logic signed [11:0] hs;
        logic [10:0]        absdx;
        logic [10:0]        rem_cb;
        logic [10:0]        rem_rb;
        logic [10:0]        rem_bx;
        logic [10:0]        rem_by;
        logic [7:0]         qbx;
        logic [7:0]         qby;
    } t_s2;

    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_geom r_s3, n_s3;
    logic  r_v1, r_v2, r_v3;
    logic  w_en1, w_en2, w_en3;

    logic signed [23:0] w_dx_sq, w_dy_sq;
    logic [23:0]        w_r0_sq;
    logic [17:0]        w_r1_sq;
    logic signed [11:0] w_ndx;
    logic [10:0]        w_cb_fix, w_rb_fix;
    logic [7:0]         w_qbx_fix, w_qby_fix;
    logic [11:0]        w_3s;

    // a stage loads when empty or when the stage after it moves
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // stage 1: offsets from center, radii, reciprocal quotient estimates
    assign w_3s = {1'b0, i_step_index, 1'b0} + {2'b00, i_step_index};

    always_comb begin
        n_s1.x         = i_pixel_x;
        n_s1.y         = i_pixel_y;
        n_s1.s         = i_step_index;
        n_s1.old_pixel = i_old_pixel;
        n_s1.new_pixel = i_new_pixel;
        n_s1.dx        = $signed({2'b00, i_pixel_x}) - CX;
        n_s1.dy        = $signed({3'b000, i_pixel_y}) - CY;
        n_s1.r0        = w_3s;
        n_s1.r1        = 13'(SHRINK_START) - $signed({1'b0, w_3s});
        n_s1.rc        = 16'(({6'd0, i_step_index} + 16'd1) * 16'(CLOSE_STRIP));
        n_s1.wmx       = W_LAST - $signed({2'b00, i_pixel_x});
        n_s1.ws        = W_LAST - $signed({2'b00, i_step_index});
        n_s1.hs        = H_LAST - $signed({2'b00, i_step_index});
        // estimate is the true quotient or one below
        n_s1.qcb = 8'((25'(i_pixel_x) * 25'(MCB)) >> RECIP_SHIFT);
        n_s1.qrb = 8'((25'(i_pixel_y) * 25'(MRB)) >> RECIP_SHIFT);
        n_s1.qbx = 8'((25'(i_pixel_x) * 25'(MBX)) >> RECIP_SHIFT);
        n_s1.qby = 8'((25'(i_pixel_y) * 25'(MBY)) >> RECIP_SHIFT);
    end

    // stage 2: squares and remainders against the estimates
    assign w_dx_sq = r_s1.dx * r_s1.dx;
    assign w_dy_sq = r_s1.dy * r_s1.dy;
    assign w_r0_sq = r_s1.r0 * r_s1.r0;
    assign w_r1_sq = r_s1.r1[8:0] * r_s1.r1[8:0];
    assign w_ndx   = -r_s1.dx;

    always_comb begin
        n_s2.x         = r_s1.x;
        n_s2.y         = r_s1.y;
        n_s2.s         = r_s1.s;
        n_s2.old_pixel = r_s1.old_pixel;
        n_s2.new_pixel = r_s1.new_pixel;
        n_s2.dx2       = w_dx_sq[20:0];
        n_s2.dy2       = w_dy_sq[20:0];
        n_s2.r0sq      = w_r0_sq;
        n_s2.r1_neg    = r_s1.r1[12];
        n_s2.r1sq      = w_r1_sq;
        n_s2.rc        = r_s1.rc;
        n_s2.wmx       = r_s1.wmx;
        n_s2.ws        = r_s1.ws;
        n_s2.hs        = r_s1.hs;
        n_s2.absdx     = r_s1.dx[11] ? w_ndx[10:0] : r_s1.dx[10:0];
        n_s2.rem_cb    = {1'b0, r_s1.x} - 11'({3'b000, r_s1.qcb} * 11'(PCB));
        n_s2.rem_rb    = {2'b00, r_s1.y} - 11'({3'b000, r_s1.qrb} * 11'(PRB));
        n_s2.rem_bx    = {1'b0, r_s1.x} - 11'({3'b000, r_s1.qbx} * 11'(PBX));
        n_s2.rem_by    = {2'b00, r_s1.y} - 11'({3'b000, r_s1.qby} * 11'(PBY));
        n_s2.qbx       = r_s1.qbx;
        n_s2.qby       = r_s1.qby;
    end

    // stage 3: distance sum, one-step quotient correction
    assign w_cb_fix  = r_s2.rem_cb - 11'(PCB);
    assign w_rb_fix  = r_s2.rem_rb - 11'(PRB);
    assign w_qbx_fix = r_s2.qbx + 8'(r_s2.rem_bx >= 11'(PBX));
    assign w_qby_fix = r_s2.qby + 8'(r_s2.rem_by >= 11'(PBY));

    always_comb begin
        n_s3.x         = r_s2.x;
        n_s3.y         = r_s2.y;
        n_s3.s         = r_s2.s;
        n_s3.old_pixel = r_s2.old_pixel;
        n_s3.new_pixel = r_s2.new_pixel;
        n_s3.d2        = {1'b0, r_s2.dx2} + {1'b0, r_s2.dy2};
        n_s3.r0sq      = r_s2.r0sq;
        n_s3.r1_neg    = r_s2.r1_neg;
        n_s3.r1sq      = r_s2.r1sq;
        n_s3.rc        = r_s2.rc;
        n_s3.wmx       = r_s2.wmx;
        n_s3.ws        = r_s2.ws;
        n_s3.hs        = r_s2.hs;
        n_s3.absdx     = r_s2.absdx;
        n_s3.mod_cb    = (r_s2.rem_cb >= 11'(PCB)) ? w_cb_fix[9:0] : r_s2.rem_cb[9:0];
        n_s3.mod_rb    = (r_s2.rem_rb >= 11'(PRB)) ? w_rb_fix[9:0] : r_s2.rem_rb[9:0];
        n_s3.blk_sum   = {1'b0, w_qbx_fix} + {1'b0, w_qby_fix};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) r_s1 <= n_s1;
        if (w_en2) r_s2 <= n_s2;
        if (w_en3) r_s3 <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_geom  = r_s3;

endmodule

>>> rtl/swm_reveal.sv
// Final stage of the wipe mask: per-mode reveal test and pixel select.
// Depends on swm_pkg; fed by swm_geom.
`timescale 1ns / 1ps

module swm_reveal (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  swm_pkg::t_geom             i_geom,
    input  logic [swm_pkg::MODE_W-1:0] i_mode,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [23:0]                o_pixel_out,
    output logic                       o_revealed
);
    import swm_pkg::*;

    logic        r_valid;
    logic [23:0] r_pixel;
    logic        r_revealed;
    logic        w_en;
    logic        w_show;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        case (i_mode)
            MODE_CIRCLE_GROW:   w_show = {2'b00, i_geom.d2} <= i_geom.r0sq;
            MODE_CIRCLE_SHRINK: w_show = i_geom.r1_neg || (i_geom.d2 >= {4'd0, i_geom.r1sq});
            MODE_DOWN:          w_show = {1'b0, i_geom.y} <= i_geom.s;
            MODE_UP:            w_show = $signed({3'b000, i_geom.y}) >= i_geom.hs;
            MODE_LEFT:          w_show = $signed({2'b00, i_geom.x}) >= i_geom.ws;
            MODE_RIGHT:         w_show = i_geom.x <= i_geom.s;
            MODE_COL_BLINDS:    w_show = i_geom.mod_cb <= i_geom.s;
            MODE_ROW_BLINDS:    w_show = i_geom.mod_rb <= i_geom.s;
            // right edge distance is negative for columns past the screen
            MODE_CLOSE:         w_show = ({6'd0, i_geom.x} < i_geom.rc) || i_geom.wmx[11]
                                         || ({5'd0, i_geom.wmx[10:0]} < i_geom.rc);
            MODE_MID:           w_show = i_geom.absdx <= {1'b0, i_geom.s};
            MODE_BLOCKS:        w_show = {1'b0, i_geom.blk_sum} <= i_geom.s;
            default:            w_show = 1'b1;  // unused codes: hard cut
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_revealed <= w_show;
            r_pixel    <= w_show ? i_geom.new_pixel : i_geom.old_pixel;
        end
    end

    assign o_valid     = r_valid;
    assign o_pixel_out = r_pixel;
    assign o_revealed  = r_revealed;

endmodule

>>> rtl/screen_transition_wipe_mask_unit.sv
// Top level of the screen wipe mask unit: config register plus 4-stage pipe.
// Depends on swm_pkg, swm_apb, swm_geom, swm_reveal.
//
//   port group       dir  handshake        carries
//   pixel in         in   i_valid/o_ready  x, y, step, old pixel, new B/G/R
//   pixel out        out  o_valid/i_ready  composed pixel, reveal flag
//   config (APB)     in   psel/penable     wipe mode register at address 0
//
// One pixel beat per cycle unless the output stalls; each beat is registered
// in turn by offsets, squares, remainder fix and mode compare before output.
// Each stage has its own valid bit and loads when empty or when the next one
// moves, so bubbles close up under a stalled output and nothing is dropped.
// Synchronous active-low reset clears the valid bits and sets mode 0.
`timescale 1ns / 1ps

module screen_transition_wipe_mask_unit #(
    parameter int SCREEN_WIDTH  = swm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = swm_pkg::SCREEN_HEIGHT_DEF,
    parameter int BLIND_COUNT   = swm_pkg::BLIND_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [9:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    input  logic [9:0]  i_step_index,
    input  logic [23:0] i_old_pixel,
    input  logic [7:0]  i_new_blue,
    input  logic [7:0]  i_new_green,
    input  logic [7:0]  i_new_red,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_pixel_out,
    output logic        o_revealed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swm_pkg::*;

    logic [MODE_W-1:0] w_mode;
    logic              w_geom_valid;
    logic              w_geom_ready;
    t_geom             w_geom;

    swm_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    swm_geom #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BLIND_COUNT   (BLIND_COUNT)
    ) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_step_index (i_step_index),
        .i_old_pixel  (i_old_pixel),
        .i_new_pixel  ({i_new_red, i_new_green, i_new_blue}),
        .o_valid      (w_geom_valid),
        .i_ready      (w_geom_ready),
        .o_geom       (w_geom)
    );

    swm_reveal u_reveal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_geom_valid),
        .o_ready     (w_geom_ready),
        .i_geom      (w_geom),
        .i_mode      (w_mode),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out),
        .o_revealed  (o_revealed)
    );

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input can only stall when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && w_geom_valid))
        else $error("input stalled with room in the pipe");

    // a config write lands in the mode register
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == 1'(REG_WIPE_MODE)))
        |=> (w_mode == $past(pwdata[MODE_W-1:0])))
        else $error("wipe mode write lost");

endmodule
